[rtl/ir_obstacle_avoid_fsm_defines.svh]
// Assertion macros shared by the obstacle-avoidance controller RTL.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef IR_OBSTACLE_AVOID_FSM_DEFINES_SVH
`define IR_OBSTACLE_AVOID_FSM_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define IROA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define IROA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/iroa_pkg.sv]
// Shared types and constants for the IR obstacle-avoidance controller.
// No dependencies; every other RTL file but the assertion header imports this package.
package iroa_pkg;

    localparam int unsigned LEVEL_W   = 16;
    localparam int unsigned FB_W      = 8;
    localparam int unsigned MODE_W    = 2;
    localparam int unsigned CMD_W     = 3;
    localparam int unsigned DUTY_W    = 7;
    localparam int unsigned CFG_IDX_W = 3;

    // Item kinds on the input channel; the fourth code means nothing.
    localparam logic [MODE_W-1:0] MODE_SAMPLE   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FEEDBACK = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TICK     = 2'd2;
    localparam logic [MODE_W-1:0] MODE_SPARE    = 2'd3;

    // Feedback byte that reports the motors as stopped.
    localparam logic [FB_W-1:0] FB_STOPPED = 8'd1;

    localparam logic [DUTY_W-1:0] DUTY_STOP   = 7'd0;
    localparam logic [DUTY_W-1:0] DUTY_CRUISE = 7'd75;
    localparam logic [DUTY_W-1:0] DUTY_AVOID  = 7'd70;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MID_NEAR,
        CFG_LEFT_NEAR,
        CFG_RIGHT_NEAR,
        CFG_MID_FAR,
        CFG_LEFT_FAR,
        CFG_RIGHT_FAR
    } cfg_idx_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_STOP,
        CMD_FORWARD,
        CMD_BACKWARD,
        CMD_PIVOT_RIGHT,
        CMD_PIVOT_LEFT
    } cmd_t;

    typedef enum logic [2:0] {
        PH_WANDER,
        PH_ACK1,
        PH_BACKING,
        PH_ACK2,
        PH_FRONT_PIVOT,
        PH_SIDE_PIVOT
    } phase_t;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [LEVEL_W-1:0] left_reading;
        logic [LEVEL_W-1:0] mid_reading;
        logic [LEVEL_W-1:0] right_reading;
        logic [FB_W-1:0]    feedback_value;
    } in_item_t;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [DUTY_W-1:0] duty;
        logic              last;
    } out_item_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] mid_near;
        logic [LEVEL_W-1:0] left_near;
        logic [LEVEL_W-1:0] right_near;
        logic [LEVEL_W-1:0] mid_clear;
        logic [LEVEL_W-1:0] left_clear;
        logic [LEVEL_W-1:0] right_clear;
    } cfg_t;

    // Up to two results caused by one item, first one first.
    typedef struct packed {
        logic [1:0] count;
        out_item_t  first;
        out_item_t  second;
    } res_pair_t;

endpackage

[rtl/iroa_if.sv]
// Valid/ready channel interfaces for input items and result items.
// Depends on iroa_pkg for the payload types.
interface iroa_in_if;
    import iroa_pkg::*;

    logic     valid;
    logic     ready;
    in_item_t item;

    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

interface iroa_out_if;
    import iroa_pkg::*;

    logic      valid;
    logic      ready;
    out_item_t item;

    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

[rtl/iroa_cfg_regs.sv]
// Threshold register file written through the plain configuration port.
// Depends on iroa_pkg.
module iroa_cfg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_en,
    input  logic [iroa_pkg::CFG_IDX_W-1:0] wr_index,
    input  logic [iroa_pkg::LEVEL_W-1:0]  wr_data,
    output iroa_pkg::cfg_t                cfg
);
    import iroa_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the register index; indexes past the list are dropped.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (cfg_idx_t'(wr_index))
                CFG_MID_NEAR:   cfg_next.mid_near    = wr_data;
                CFG_LEFT_NEAR:  cfg_next.left_near   = wr_data;
                CFG_RIGHT_NEAR: cfg_next.right_near  = wr_data;
                CFG_MID_FAR:    cfg_next.mid_clear   = wr_data;
                CFG_LEFT_FAR:   cfg_next.left_clear  = wr_data;
                CFG_RIGHT_FAR:  cfg_next.right_clear = wr_data;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[rtl/iroa_in_stage.sv]
// Input register: captures one beat from the input channel.
// Depends on iroa_pkg and iroa_in_if.
module iroa_in_stage (
    input  logic             clk,
    input  logic             rst_n,
    iroa_in_if.sink          in_ch,
    input  logic             fire,
    output logic             valid,
    output iroa_pkg::in_item_t item
);
    import iroa_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;
    logic     in_fire;

    // The register takes a new beat when empty or when its item moves on.
    assign in_ch.ready = !valid_reg || fire;
    assign in_fire     = in_ch.valid && in_ch.ready;

    always_comb
    begin
        if (in_fire)
        begin
            valid_next = 1'b1;
        end
        else if (fire)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            item_reg <= in_ch.item;
        end
    end

    assign valid = valid_reg;
    assign item  = item_reg;

endmodule

[rtl/iroa_step.sv]
// Phase machine and sensor levels: works out the results of one item.
// Depends on iroa_pkg and ir_obstacle_avoid_fsm_defines.svh.
`include "ir_obstacle_avoid_fsm_defines.svh"

module iroa_step (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  iroa_pkg::in_item_t  item,
    input  iroa_pkg::cfg_t      cfg,
    output iroa_pkg::res_pair_t res
);
    import iroa_pkg::*;

    phase_t             phase_reg;
    phase_t             phase_next;
    logic [LEVEL_W-1:0] left_level_reg;
    logic [LEVEL_W-1:0] left_level_next;
    logic [LEVEL_W-1:0] mid_level_reg;
    logic [LEVEL_W-1:0] mid_level_next;
    logic [LEVEL_W-1:0] right_level_reg;
    logic [LEVEL_W-1:0] right_level_next;
    logic               side_is_left_reg;
    logic               side_is_left_next;
    logic               front_pending_reg;
    logic               front_pending_next;

    logic               is_sample;
    logic               is_ack;
    logic               is_tick;
    logic [LEVEL_W-1:0] left_cur;
    logic [LEVEL_W-1:0] mid_cur;
    logic [LEVEL_W-1:0] right_cur;
    logic               front_clear;
    logic               side_clear;
    logic               obst_mid;
    logic               obst_left;
    logic               obst_right;
    logic               obst_any;
    logic               left_higher;

    // Build one result with the duty that goes with its command.
    function automatic out_item_t mk_result(cmd_t cmd);
        out_item_t r;
        r.command = cmd;
        r.last    = 1'b0;
        case (cmd)
            CMD_STOP:    r.duty = DUTY_STOP;
            CMD_FORWARD: r.duty = DUTY_CRUISE;
            default:     r.duty = DUTY_AVOID;
        endcase
        return r;
    endfunction

    // Item decode; a sample's readings count at once for the exit checks.
    assign is_sample = (item.mode == MODE_SAMPLE);
    assign is_ack    = (item.mode == MODE_FEEDBACK) && (item.feedback_value == FB_STOPPED);
    assign is_tick   = (item.mode == MODE_TICK);
    assign left_cur  = is_sample ? item.left_reading  : left_level_reg;
    assign mid_cur   = is_sample ? item.mid_reading   : mid_level_reg;
    assign right_cur = is_sample ? item.right_reading : right_level_reg;

    // Threshold compares.
    assign front_clear = (mid_cur <= cfg.mid_clear);
    assign side_clear  = side_is_left_reg ? (left_cur <= cfg.left_clear)
                                          : (right_cur <= cfg.right_clear);
    assign obst_mid    = (mid_level_reg > cfg.mid_near);
    assign obst_left   = (left_level_reg > cfg.left_near);
    assign obst_right  = (right_level_reg > cfg.right_near);
    assign obst_any    = obst_mid || obst_left || obst_right;
    assign left_higher = (left_level_reg > right_level_reg);

    // Next phase.
    always_comb
    begin
        phase_next = phase_reg;
        if (fire)
        begin
            case (phase_reg)
                PH_WANDER:
                begin
                    if (is_tick && obst_any)
                    begin
                        phase_next = PH_ACK1;
                    end
                end
                PH_ACK1:
                begin
                    if (is_ack)
                    begin
                        if (front_pending_reg)
                        begin
                            phase_next = front_clear ? PH_ACK2 : PH_BACKING;
                        end
                        else
                        begin
                            phase_next = side_clear ? PH_WANDER : PH_SIDE_PIVOT;
                        end
                    end
                end
                PH_BACKING:
                begin
                    if (is_sample && front_clear)
                    begin
                        phase_next = PH_ACK2;
                    end
                end
                PH_ACK2:
                begin
                    if (is_ack)
                    begin
                        phase_next = front_clear ? PH_WANDER : PH_FRONT_PIVOT;
                    end
                end
                PH_FRONT_PIVOT:
                begin
                    if (is_sample && front_clear)
                    begin
                        phase_next = PH_WANDER;
                    end
                end
                PH_SIDE_PIVOT:
                begin
                    if (is_sample && side_clear)
                    begin
                        phase_next = PH_WANDER;
                    end
                end
                default:
                begin
                    phase_next = PH_WANDER;
                end
            endcase
        end
    end

    // Results of the current item.
    always_comb
    begin
        res = '0;
        case (phase_reg)
            PH_WANDER:
            begin
                if (is_tick)
                begin
                    res.count = 2'd1;
                    res.first = mk_result(obst_any ? CMD_STOP : CMD_FORWARD);
                end
            end
            PH_ACK1:
            begin
                if (is_ack)
                begin
                    if (front_pending_reg)
                    begin
                        res.first  = mk_result(CMD_BACKWARD);
                        res.second = mk_result(CMD_STOP);
                        res.count  = front_clear ? 2'd2 : 2'd1;
                    end
                    else
                    begin
                        res.first  = mk_result(side_is_left_reg ? CMD_PIVOT_RIGHT
                                                                : CMD_PIVOT_LEFT);
                        res.second = mk_result(CMD_FORWARD);
                        res.count  = side_clear ? 2'd2 : 2'd1;
                    end
                end
            end
            PH_BACKING:
            begin
                if (is_sample && front_clear)
                begin
                    res.count = 2'd1;
                    res.first = mk_result(CMD_STOP);
                end
            end
            PH_ACK2:
            begin
                if (is_ack)
                begin
                    res.first  = mk_result(left_higher ? CMD_PIVOT_RIGHT : CMD_PIVOT_LEFT);
                    res.second = mk_result(CMD_FORWARD);
                    res.count  = front_clear ? 2'd2 : 2'd1;
                end
            end
            PH_FRONT_PIVOT:
            begin
                if (is_sample && front_clear)
                begin
                    res.count = 2'd1;
                    res.first = mk_result(CMD_FORWARD);
                end
            end
            PH_SIDE_PIVOT:
            begin
                if (is_sample && side_clear)
                begin
                    res.count = 2'd1;
                    res.first = mk_result(CMD_FORWARD);
                end
            end
            default:
            begin
                res = '0;
            end
        endcase
        res.first.last  = (res.count == 2'd1);
        res.second.last = 1'b1;
    end

    // Sensor levels and obstacle flags.
    always_comb
    begin
        left_level_next    = left_level_reg;
        mid_level_next     = mid_level_reg;
        right_level_next   = right_level_reg;
        side_is_left_next  = side_is_left_reg;
        front_pending_next = front_pending_reg;
        if (fire && is_sample)
        begin
            left_level_next  = item.left_reading;
            mid_level_next   = item.mid_reading;
            right_level_next = item.right_reading;
        end
        if (fire && is_tick && (phase_reg == PH_WANDER))
        begin
            if (obst_mid)
            begin
                front_pending_next = 1'b1;
            end
            else if (obst_left)
            begin
                front_pending_next = 1'b0;
                side_is_left_next  = 1'b1;
            end
            else if (obst_right)
            begin
                front_pending_next = 1'b0;
                side_is_left_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_WANDER;
            left_level_reg    <= '0;
            mid_level_reg     <= '0;
            right_level_reg   <= '0;
            side_is_left_reg  <= 1'b0;
            front_pending_reg <= 1'b0;
        end
        else
        begin
            phase_reg         <= phase_next;
            left_level_reg    <= left_level_next;
            mid_level_reg     <= mid_level_next;
            right_level_reg   <= right_level_next;
            side_is_left_reg  <= side_is_left_next;
            front_pending_reg <= front_pending_next;
        end
    end

    // Only a stop acknowledge can produce two results.
    `IROA_ASSERT_SAME(a_pair_from_ack, fire && (res.count == 2'd2), is_ack, "pair not from an ack")
    // A tick outside wander is ignored.
    `IROA_ASSERT_SAME(a_tick_quiet, fire && is_tick && (phase_reg != PH_WANDER), res.count == 2'd0, "tick gave result outside wander")
    // A stop on a tick always leads into the first stop wait.
    `IROA_ASSERT_NEXT(a_tick_stop, fire && is_tick && (phase_reg == PH_WANDER) && obst_any, phase_reg == PH_ACK1, "stop without ack wait")

endmodule

[rtl/iroa_out_buf.sv]
// Result register: holds up to two results and hands them out one beat each.
// Depends on iroa_pkg, iroa_out_if and ir_obstacle_avoid_fsm_defines.svh.
`include "ir_obstacle_avoid_fsm_defines.svh"

module iroa_out_buf (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  iroa_pkg::res_pair_t res,
    output logic                free,
    iroa_out_if.source          out_ch
);
    import iroa_pkg::*;

    logic [1:0] rem_reg;
    logic [1:0] rem_next;
    out_item_t  head_reg;
    out_item_t  head_next;
    out_item_t  tail_reg;
    out_item_t  tail_next;
    logic       out_fire;
    logic       load;

    assign out_ch.valid = (rem_reg != 2'd0);
    assign out_ch.item  = head_reg;
    assign out_fire     = out_ch.valid && out_ch.ready;

    // Room for a new pair once the last held result leaves this cycle.
    assign free = (rem_reg == 2'd0) || ((rem_reg == 2'd1) && out_ch.ready);
    assign load = fire && (res.count != 2'd0);

    always_comb
    begin
        if (load)
        begin
            rem_next = res.count;
        end
        else if (out_fire)
        begin
            rem_next = rem_reg - 2'd1;
        end
        else
        begin
            rem_next = rem_reg;
        end
    end

    // The second result moves up once the first has gone.
    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        if (load)
        begin
            head_next = res.first;
            tail_next = res.second;
        end
        else if (out_fire && (rem_reg == 2'd2))
        begin
            head_next = tail_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= 2'd0;
        end
        else
        begin
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

    // A pair is never loaded over a result still waiting.
    `IROA_ASSERT_SAME(a_load_free, load, (rem_reg == 2'd0) || ((rem_reg == 2'd1) && out_fire), "load over pending result")
    // A shown result without the last flag always has its partner behind it.
    `IROA_ASSERT_SAME(a_partner_held, out_ch.valid && !head_reg.last, rem_reg == 2'd2, "non-final result without partner")
    // After the first of a pair leaves, the second is shown next.
    `IROA_ASSERT_NEXT(a_second_follows, out_fire && (rem_reg == 2'd2), out_ch.valid && out_ch.item.last, "second result lost")

endmodule

[rtl/ir_obstacle_avoid_fsm.sv]
// Top level of the IR obstacle-avoidance controller.
// Depends on iroa_pkg, iroa_if, iroa_cfg_regs, iroa_in_stage, iroa_step, iroa_out_buf.
//
//  Channel  Direction  Handshake          Beat
//  in_ch    sink       valid/ready        mode, three IR readings, feedback byte
//  out_ch   source     valid/ready        command, duty, last
//  cfg_wr   sink       cfg_wr_en only     6 threshold registers, 16 bits each
//
// Throughput is one item per cycle while each item gives at most one result and
// out_ch takes a beat every cycle; an item that gives two results holds the result
// register until its second result leaves, so the next item waits.
// An item passes the input register, then the phase logic into the result register.
// Reset clears the thresholds, the levels, the phase (wander) and all valid flags.
// A stall on out_ch backs up through the input register to in_ch.ready.
module ir_obstacle_avoid_fsm (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [iroa_pkg::CFG_IDX_W-1:0] cfg_wr_index,
    input  logic [iroa_pkg::LEVEL_W-1:0]   cfg_wr_data,
    iroa_in_if.sink                        in_ch,
    iroa_out_if.source                     out_ch
);
    import iroa_pkg::*;

    cfg_t      cfg;
    logic      stage_valid;
    in_item_t  stage_item;
    res_pair_t res;
    logic      free;
    logic      fire;

    // The held item is processed when the result register has room.
    assign fire = stage_valid && free;

    iroa_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_wr_en),
        .wr_index (cfg_wr_index),
        .wr_data  (cfg_wr_data),
        .cfg      (cfg)
    );

    iroa_in_stage u_in (
        .clk   (clk),
        .rst_n (rst_n),
        .in_ch (in_ch),
        .fire  (fire),
        .valid (stage_valid),
        .item  (stage_item)
    );

    iroa_step u_step (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (stage_item),
        .cfg   (cfg),
        .res   (res)
    );

    iroa_out_buf u_out (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .res    (res),
        .free   (free),
        .out_ch (out_ch)
    );

endmodule
